// ----- hdl/rbm_pkg.sv -----
// Package for the random buffer mutator: sizes, generator constants, mutation
// kinds, microcode word layout and the microcode program itself.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbm_pkg;

  // Buffer and mutation limits
  localparam int BUFFER_DEPTH     = 64;
  localparam int MAX_BIT_FLIPS    = 32;   // power of two
  localparam int MAX_BYTE_CHANGES = 8;    // power of two

  // Byte store geometry
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int FILL_W      = 7;
  localparam int CNT_W       = 8;
  localparam int UPC_W       = 5;

  // Remainder unit: four dividend bits per cycle
  localparam int DIV_DIGIT = 4;
  localparam int DIV_STEPS = 32 / DIV_DIGIT;
  localparam int DCNT_W    = 3;

  // Generator
  localparam logic [31:0] LCG_MUL    = 32'd29943829;
  localparam logic [31:0] LCG_INC    = 32'd3;
  localparam logic [31:0] SEED_RESET = 32'd1;

  // Known byte values and the id bytes that may be kept
  localparam logic [7:0]        KNOWN_EVEN = 8'h80;
  localparam logic [7:0]        KNOWN_ODD  = 8'h7F;
  localparam logic [ADDR_W-1:0] KEEP_BASE  = 6'd8;

  typedef enum logic [1:0] {
    KIND_FLIP   = 2'd0,
    KIND_INVERT = 2'd1,
    KIND_KNOWN  = 2'd2
  } kind_t;

  // Datapath operations, one per microcode step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_KRD,
    OP_KCAP,
    OP_DRAW,
    OP_SKIND,
    OP_SCNT,
    OP_DINIT,
    OP_DSTEP,
    OP_RDPOS,
    OP_DRAW_FLIP,
    OP_MODIFY,
    OP_KNOWN,
    OP_CLR_IDX,
    OP_RESTORE,
    OP_ERD,
    OP_ELD,
    OP_DONE
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_LAST,
    C_IDX_NOT3,
    C_CNT_DONE,
    C_DIV_MORE,
    C_KIND_KNOWN,
    C_EMIT_MORE
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  tgt;
  } uword_t;

  // Step addresses
  localparam upc_t ST_LOAD    = 5'd0;
  localparam upc_t ST_KRD     = 5'd1;
  localparam upc_t ST_KCAP    = 5'd2;
  localparam upc_t ST_DKIND   = 5'd3;
  localparam upc_t ST_SKIND   = 5'd4;
  localparam upc_t ST_DCNT    = 5'd5;
  localparam upc_t ST_SCNT    = 5'd6;
  localparam upc_t ST_LOOP    = 5'd7;
  localparam upc_t ST_DPOS    = 5'd8;
  localparam upc_t ST_DINIT   = 5'd9;
  localparam upc_t ST_DSTEP   = 5'd10;
  localparam upc_t ST_RDPOS   = 5'd11;
  localparam upc_t ST_DBIT    = 5'd12;
  localparam upc_t ST_MODIFY  = 5'd13;
  localparam upc_t ST_KNOWN   = 5'd14;
  localparam upc_t ST_RINIT   = 5'd15;
  localparam upc_t ST_RESTORE = 5'd16;
  localparam upc_t ST_EINIT   = 5'd17;
  localparam upc_t ST_ERD     = 5'd18;
  localparam upc_t ST_ELD     = 5'd19;
  localparam upc_t ST_DONE    = 5'd20;

  function automatic uword_t mk(input op_t op, input cond_t cond, input upc_t tgt);
    uword_t w;
    w.op   = op;
    w.cond = cond;
    w.tgt  = tgt;
    return w;
  endfunction

  // Microcode program
  function automatic uword_t ucode_rom(input upc_t a);
    uword_t w;
    unique case (a)
      ST_LOAD:    w = mk(OP_LOAD,      C_NOT_LAST,   ST_LOAD);
      ST_KRD:     w = mk(OP_KRD,       C_NEXT,       ST_LOAD);
      ST_KCAP:    w = mk(OP_KCAP,      C_IDX_NOT3,   ST_KRD);
      ST_DKIND:   w = mk(OP_DRAW,      C_NEXT,       ST_LOAD);
      ST_SKIND:   w = mk(OP_SKIND,     C_NEXT,       ST_LOAD);
      ST_DCNT:    w = mk(OP_DRAW,      C_NEXT,       ST_LOAD);
      ST_SCNT:    w = mk(OP_SCNT,      C_NEXT,       ST_LOAD);
      ST_LOOP:    w = mk(OP_NOP,       C_CNT_DONE,   ST_RINIT);
      ST_DPOS:    w = mk(OP_DRAW,      C_NEXT,       ST_LOAD);
      ST_DINIT:   w = mk(OP_DINIT,     C_NEXT,       ST_LOAD);
      ST_DSTEP:   w = mk(OP_DSTEP,     C_DIV_MORE,   ST_DSTEP);
      ST_RDPOS:   w = mk(OP_RDPOS,     C_KIND_KNOWN, ST_KNOWN);
      ST_DBIT:    w = mk(OP_DRAW_FLIP, C_NEXT,       ST_LOAD);
      ST_MODIFY:  w = mk(OP_MODIFY,    C_ALWAYS,     ST_LOOP);
      ST_KNOWN:   w = mk(OP_KNOWN,     C_ALWAYS,     ST_LOOP);
      ST_RINIT:   w = mk(OP_CLR_IDX,   C_NEXT,       ST_LOAD);
      ST_RESTORE: w = mk(OP_RESTORE,   C_IDX_NOT3,   ST_RESTORE);
      ST_EINIT:   w = mk(OP_CLR_IDX,   C_NEXT,       ST_LOAD);
      ST_ERD:     w = mk(OP_ERD,       C_NEXT,       ST_LOAD);
      ST_ELD:     w = mk(OP_ELD,       C_EMIT_MORE,  ST_ERD);
      ST_DONE:    w = mk(OP_DONE,      C_ALWAYS,     ST_LOAD);
      default:    w = mk(OP_NOP,       C_ALWAYS,     ST_LOAD);
    endcase
    return w;
  endfunction

  // x mod 3 by folding: 2^16, 2^8, 2^4 and 2^2 are all 1 mod 3
  function automatic logic [1:0] mod3_32(input logic [31:0] x);
    logic [16:0] a;
    logic [9:0]  b;
    logic [5:0]  c;
    logic [4:0]  d;
    logic [2:0]  e;
    logic [2:0]  f;
    a = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    b = {1'b0, a[16:8]} + {2'b00, a[7:0]};
    c = b[9:4] + {2'b00, b[3:0]};
    d = {1'b0, c[5:2]} + {3'b000, c[1:0]};
    e = d[4:2] + {1'b0, d[1:0]};
    f = {2'b00, e[2]} + {1'b0, e[1:0]};
    if (f >= 3'd3) begin
      f = f - 3'd3;
    end
    return f[1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rbm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/random_buffer_mutator_top.sv -----
// Random buffer mutator top level: microcoded sequencer, generator,
// remainder unit and output register. Uses rbm_pkg and rbm_ram.
//
//  channel | direction | signals                          | payload
//  in_     | sink      | in_tvalid/in_tready              | tdata: data_byte, tlast: last,
//          |           |                                  | tuser: keep_ids
//  out_    | source    | out_tvalid/out_tready            | tdata: data_byte_res,
//          |           |                                  | tlast: last_res, tuser: mutation_kind
//  cfg_    | sink      | cfg_valid/cfg_ready (always 1)   | cfg_data: seed
//
// Bytes load at one per cycle while in_tvalid is high. After the last byte the id
// bytes are saved, then kind and count are picked, then each change (bit flip,
// inversion or known byte) is dominated by the remainder unit that takes
// position mod length four bits a cycle; the loop is then left and the ids
// are restored.
// Output reads and loads one byte at a time through the single RAM read port.
// Reset is synchronous and active low; the byte store is not cleared.
// A stalled output register holds the sequencer at its read step.
`timescale 1ns / 1ps
`default_nettype none

module random_buffer_mutator_top
  import rbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last
  input  wire logic        in_tuser,   // [0] keep_ids
  // mutated bytes
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] data_byte_res
  output logic             out_tlast,  // last_res
  output logic [1:0]       out_tuser,  // [1:0] mutation_kind
  // seed register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  // Sequencer
  upc_t   upc_r, upc_nxt;
  uword_t uw;
  logic   stall;
  logic   take_jump;

  // Control registers
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [31:0]       rng_r, rng_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  logic [7:0]        kept_r [4];
  kind_t             kind_r;
  logic              keep_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] rem_r, rem_nxt;
  logic [31:0]       dvd_r;
  logic [7:0]        out_data_r;
  logic              out_last_r;
  kind_t             out_kind_r;

  // RAM port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic              in_xfer, out_xfer, cfg_xfer;
  logic [31:0]       lcg_next;
  logic              emit_last;
  logic [FILL_W-1:0] restore_addr;
  logic              has_room;

  rbm_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign uw        = ucode_rom(upc_r);
  assign in_tready = (uw.op == OP_LOAD);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid & in_tready;
  assign out_xfer  = out_valid_r & out_tready;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

  assign lcg_next     = rng_r * LCG_MUL + LCG_INC;
  assign emit_last    = ((idx_r + CNT_W'(1)) == CNT_W'(fill_r));
  assign restore_addr = FILL_W'(KEEP_BASE) + FILL_W'(idx_r[1:0]);
  assign has_room     = (fill_r < FILL_W'(BUFFER_DEPTH));

  // Step hold: waiting on input, or on a full output register
  always_comb begin
    stall = 1'b0;
    if (uw.op == OP_LOAD && !in_tvalid) begin
      stall = 1'b1;
    end
    if (uw.op == OP_ERD && out_valid_r && !out_tready) begin
      stall = 1'b1;
    end
  end

  // Jump condition decode
  always_comb begin
    unique case (uw.cond)
      C_NEXT:       take_jump = 1'b0;
      C_ALWAYS:     take_jump = 1'b1;
      C_NOT_LAST:   take_jump = !in_tlast;
      C_IDX_NOT3:   take_jump = (idx_r[1:0] != 2'd3);
      C_CNT_DONE:   take_jump = (idx_r == cnt_r);
      C_DIV_MORE:   take_jump = (dcnt_r != DCNT_W'(DIV_STEPS - 1));
      C_KIND_KNOWN: take_jump = (kind_r == KIND_KNOWN);
      C_EMIT_MORE:  take_jump = !emit_last;
      default:      take_jump = 1'b0;
    endcase
  end

  // Next step address
  always_comb begin
    if (stall) begin
      upc_nxt = upc_r;
    end else if (take_jump) begin
      upc_nxt = uw.tgt;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  // RAM port decode
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rem_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = rem_r;
    unique case (uw.op)
      OP_LOAD: begin
        ram_we    = in_xfer && has_room;
        ram_waddr = fill_r[ADDR_W-1:0];
        ram_wdata = in_tdata;
      end
      OP_KRD: begin
        ram_re    = 1'b1;
        ram_raddr = restore_addr[ADDR_W-1:0];
      end
      OP_RDPOS: begin
        ram_re = 1'b1;
      end
      OP_MODIFY: begin
        ram_we    = 1'b1;
        ram_wdata = (kind_r == KIND_FLIP) ? (ram_rdata ^ (8'd1 << rng_r[2:0]))
                                          : ~ram_rdata;
      end
      OP_KNOWN: begin
        ram_we    = 1'b1;
        ram_wdata = idx_r[0] ? KNOWN_ODD : KNOWN_EVEN;
      end
      OP_RESTORE: begin
        ram_we    = keep_r && (restore_addr < fill_r);
        ram_waddr = restore_addr[ADDR_W-1:0];
        ram_wdata = kept_r[idx_r[1:0]];
      end
      OP_ERD: begin
        ram_re    = !stall;
        ram_raddr = idx_r[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Remainder unit: four restoring steps on the position remainder
  always_comb begin
    logic [ADDR_W:0]   t;
    logic [ADDR_W-1:0] r;
    r = rem_r;
    for (int j = 0; j < DIV_DIGIT; j++) begin
      t = {r, dvd_r[31 - j]};
      if (t >= fill_r) begin
        t = t - fill_r;
      end
      r = t[ADDR_W-1:0];
    end
    rem_nxt = r;
  end

  // Control register next values
  always_comb begin
    fill_nxt      = fill_r;
    rng_nxt       = rng_r;
    idx_nxt       = idx_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    unique case (uw.op)
      OP_LOAD: begin
        if (in_xfer) begin
          idx_nxt = '0;
          if (has_room) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
      end
      OP_KCAP:      idx_nxt  = idx_r + CNT_W'(1);
      OP_DRAW:      rng_nxt  = lcg_next;
      OP_DRAW_FLIP: rng_nxt  = (kind_r == KIND_FLIP) ? lcg_next : rng_r;
      OP_SCNT:      idx_nxt  = '0;
      OP_DINIT:     dcnt_nxt = '0;
      OP_DSTEP:     dcnt_nxt = dcnt_r + DCNT_W'(1);
      OP_MODIFY:    idx_nxt  = idx_r + CNT_W'(1);
      OP_KNOWN:     idx_nxt  = idx_r + CNT_W'(1);
      OP_CLR_IDX:   idx_nxt  = '0;
      OP_RESTORE:   idx_nxt  = idx_r + CNT_W'(1);
      OP_ELD: begin
        idx_nxt       = idx_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
      end
      OP_DONE:      fill_nxt = '0;
      default: begin
      end
    endcase
    if (cfg_xfer) begin
      rng_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ST_LOAD;
      fill_r      <= '0;
      rng_r       <= SEED_RESET;
      idx_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      fill_r      <= fill_nxt;
      rng_r       <= rng_nxt;
      idx_r       <= idx_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_LOAD: begin
        if (in_xfer && in_tlast) begin
          keep_r <= in_tuser;
        end
      end
      OP_KCAP:  kept_r[idx_r[1:0]] <= ram_rdata;
      OP_SKIND: kind_r <= kind_t'(mod3_32(rng_r));
      OP_SCNT: begin
        if (kind_r == KIND_FLIP) begin
          cnt_r <= CNT_W'(rng_r % MAX_BIT_FLIPS);
        end else begin
          cnt_r <= CNT_W'(rng_r % MAX_BYTE_CHANGES);
        end
      end
      OP_DINIT: begin
        dvd_r <= rng_r;
        rem_r <= '0;
      end
      OP_DSTEP: begin
        dvd_r <= dvd_r << DIV_DIGIT;
        rem_r <= rem_nxt;
      end
      OP_ELD: begin
        out_data_r <= ram_rdata;
        out_last_r <= emit_last;
        out_kind_r <= kind_r;
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_pos_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ST_RDPOS) |-> (FILL_W'(rem_r) < fill_r))
    else $error("mutation position outside buffer length");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("illegal mutation kind on output");

  a_write_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && upc_r != ST_LOAD) |-> (FILL_W'(ram_waddr) < fill_r))
    else $error("store write outside buffer length");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> (upc_r == ST_KRD))
    else $error("last transfer did not start mutation");

endmodule

`default_nettype wire
